FILE: rtl/radial_vignette_darkener_core_macros.svh
// Assertion macros shared by the vignette darkener RTL.
`ifndef RADIAL_VIGNETTE_DARKENER_CORE_MACROS_SVH
`define RADIAL_VIGNETTE_DARKENER_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define RVD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvd: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define RVD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rvd: next-cycle check failed");
`else
`define RVD_ASSERT_NOW(lbl, ante, cons)
`define RVD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rvd_pkg.sv
// Types and constants for the radial vignette darkener.
package rvd_pkg;

  localparam int unsigned CFG_W   = 13;  // frame size register width
  localparam int unsigned COORD_W = 12;  // pixel coordinate width
  localparam int unsigned CHAN_W  = 8;   // color channel width
  localparam int unsigned DIST_W  = 25;  // squared distance width
  localparam int unsigned DIV_STEPS = 8; // quotient bits, one per divider cell
  localparam int unsigned NUM_W   = DIST_W + 8;              // dist_sq * 154
  localparam int unsigned DSH_W   = DIST_W + DIV_STEPS - 1;  // divisor, pre-shifted
  localparam int unsigned SCALE_W = 9;

  // Register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1280;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd720;

  localparam logic [DIV_STEPS-1:0] STRENGTH_MAX = 8'd154;
  localparam logic [SCALE_W-1:0]   SCALE_ONE    = 9'd256;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // Item as it travels along the divider chain
  typedef struct packed {
    logic                 sat;
    logic [NUM_W-1:0]     rem;
    logic [DSH_W-1:0]     dsh;
    logic [DIV_STEPS-1:0] quot;
    pix_t                 pix;
  } cell_data_t;

endpackage

FILE: rtl/rvd_front.sv
// Front pipeline: centre, offsets, squares and divider operands.
`include "radial_vignette_darkener_core_macros.svh"
module rvd_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rvd_pkg::CFG_W-1:0]     frame_width,
  input  logic [rvd_pkg::CFG_W-1:0]     frame_height,
  input  logic                          in_valid,
  output logic                          up_ready,
  input  logic [rvd_pkg::COORD_W-1:0]   pixel_x,
  input  logic [rvd_pkg::COORD_W-1:0]   pixel_y,
  input  rvd_pkg::pix_t                 pix_in,
  output logic                          out_valid,
  output rvd_pkg::cell_data_t           out_data,
  input  logic                          down_ready
);
  import rvd_pkg::*;

  localparam int unsigned REG_MAX = (1 << CFG_W) - 1;
  localparam int unsigned DIM_CAP = (MAX_DIM < REG_MAX) ? MAX_DIM : REG_MAX;
  localparam logic [CFG_W-1:0] DIM_LIM = CFG_W'(DIM_CAP);
  localparam int unsigned CW = $clog2(DIM_CAP / 2 + 1);
  localparam int unsigned SQC_W = 2 * CW;
  localparam int unsigned SQD_W = 2 * COORD_W;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4, r5;

  // Stage 1: pixel and centre
  logic [COORD_W-1:0] px1, py1;
  logic [CW-1:0]      cx1, cy1;
  pix_t               pix1;
  // Stage 2: offsets
  logic [COORD_W-1:0] dx2, dy2;
  logic [CW-1:0]      cx2, cy2;
  pix_t               pix2;
  // Stage 3: squares
  logic [SQD_W-1:0]   sqx3, sqy3;
  logic [SQC_W-1:0]   sqcx3, sqcy3;
  pix_t               pix3;
  // Stage 4: sums
  logic [DIST_W-1:0]  dist4, max4;
  pix_t               pix4;

  logic [CFG_W-1:0] fw_lim, fh_lim;
  cell_data_t       s5_next;

  // Clamp frame size; stage 1 halves it
  assign fw_lim = (frame_width  > DIM_LIM) ? DIM_LIM : frame_width;
  assign fh_lim = (frame_height > DIM_LIM) ? DIM_LIM : frame_height;

  // Advance a stage when it is empty or its successor advances
  assign r5 = !out_valid || down_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign up_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) out_valid <= v4;
    end
  end

  // Divider operands and saturation flag
  always_comb begin
    s5_next.sat  = dist4 >= max4;
    s5_next.rem  = NUM_W'(dist4) * NUM_W'(STRENGTH_MAX);
    s5_next.dsh  = {max4, (DIV_STEPS - 1)'(0)};
    s5_next.quot = '0;
    s5_next.pix  = pix4;
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (r1) begin
      px1  <= pixel_x;
      py1  <= pixel_y;
      cx1  <= CW'(fw_lim >> 1);
      cy1  <= CW'(fh_lim >> 1);
      pix1 <= pix_in;
    end
    if (r2) begin
      dx2  <= (px1 >= COORD_W'(cx1)) ? px1 - COORD_W'(cx1) : COORD_W'(cx1) - px1;
      dy2  <= (py1 >= COORD_W'(cy1)) ? py1 - COORD_W'(cy1) : COORD_W'(cy1) - py1;
      cx2  <= cx1;
      cy2  <= cy1;
      pix2 <= pix1;
    end
    if (r3) begin
      sqx3  <= SQD_W'(dx2) * SQD_W'(dx2);
      sqy3  <= SQD_W'(dy2) * SQD_W'(dy2);
      sqcx3 <= SQC_W'(cx2) * SQC_W'(cx2);
      sqcy3 <= SQC_W'(cy2) * SQC_W'(cy2);
      pix3  <= pix2;
    end
    if (r4) begin
      dist4 <= DIST_W'(sqx3) + DIST_W'(sqy3);
      max4  <= DIST_W'(sqcx3) + DIST_W'(sqcy3);
      pix4  <= pix3;
    end
    if (r5) begin
      out_data <= s5_next;
    end
  end

  // A zero corner distance must always saturate
  `RVD_ASSERT_NOW(a_zero_max_sat, out_valid && (out_data.dsh == '0), out_data.sat)
  // An unsaturated numerator stays below 256 times the divisor
  `RVD_ASSERT_NOW(a_num_bound, out_valid && !out_data.sat, out_data.rem < {out_data.dsh, 1'b0})

endmodule

FILE: rtl/rvd_div_cell.sv
// One restoring-division cell: settles one quotient bit and passes the item on.
`include "radial_vignette_darkener_core_macros.svh"
module rvd_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rvd_pkg::cell_data_t in_data,
  output logic                up_ready,
  output logic                out_valid,
  output rvd_pkg::cell_data_t out_data,
  input  logic                down_ready
);
  import rvd_pkg::*;

  logic       ge;
  cell_data_t data_next;

  assign up_ready = !out_valid || down_ready;

  // Subtract the shifted divisor when it fits, then halve it
  always_comb begin
    ge = in_data.rem >= NUM_W'(in_data.dsh);
    data_next      = in_data;
    data_next.rem  = ge ? in_data.rem - NUM_W'(in_data.dsh) : in_data.rem;
    data_next.dsh  = in_data.dsh >> 1;
    data_next.quot = {in_data.quot[DIV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      out_data <= data_next;
    end
  end

  // Hold the item while the next cell is full
  `RVD_ASSERT_NEXT(a_cell_hold, out_valid && !down_ready, out_valid && $stable(out_data))
  // Partial remainder stays below twice the current divisor
  `RVD_ASSERT_NOW(a_rem_bound, in_valid && !in_data.sat, in_data.rem < {in_data.dsh, 1'b0})

endmodule

FILE: rtl/rvd_scale.sv
// Output stage: turn strength into a scale, weight the channels, hold the result.
`include "radial_vignette_darkener_core_macros.svh"
module rvd_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  rvd_pkg::cell_data_t         in_data,
  output logic                        up_ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rvd_pkg::CHAN_W-1:0]  red_out,
  output logic [rvd_pkg::CHAN_W-1:0]  green_out,
  output logic [rvd_pkg::CHAN_W-1:0]  blue_out
);
  import rvd_pkg::*;

  localparam int unsigned PROD_W = CHAN_W + SCALE_W;

  logic [DIV_STEPS-1:0] strength;
  logic [SCALE_W-1:0]   scale;
  logic [PROD_W-1:0]    prod_r, prod_g, prod_b;

  assign up_ready = !out_valid || !out_stall;

  // Saturate strength, then weight each channel by 256 - strength
  always_comb begin
    strength = in_data.sat ? STRENGTH_MAX : in_data.quot;
    scale    = SCALE_ONE - SCALE_W'(strength);
    prod_r   = PROD_W'(in_data.pix.red)   * PROD_W'(scale);
    prod_g   = PROD_W'(in_data.pix.green) * PROD_W'(scale);
    prod_b   = PROD_W'(in_data.pix.blue)  * PROD_W'(scale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      red_out   <= prod_r[CHAN_W +: CHAN_W];
      green_out <= prod_g[CHAN_W +: CHAN_W];
      blue_out  <= prod_b[CHAN_W +: CHAN_W];
    end
  end

  // Darkening never brightens a channel
  `RVD_ASSERT_NEXT(a_no_gain, in_valid && up_ready, (red_out <= $past(in_data.pix.red)) && (green_out <= $past(in_data.pix.green)) && (blue_out <= $past(in_data.pix.blue)))

endmodule

FILE: rtl/radial_vignette_darkener_core.sv
// Top level of the radial vignette darkener.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_en                cfg_index, cfg_data
//   in       in         in_valid / in_stall   pixel_x, pixel_y, red_in, green_in, blue_in
//   out      out        out_valid / out_stall red_out, green_out, blue_out
//
// Takes one pixel per clock while in_stall is low; the path is five front stages, eight
// divider cells (one quotient bit each) and the output register.
// The eight-cell restoring divider chain is most of the latency; one per cycle unstalled.
// Reset clears all stage valids and loads frame size 1280 x 720.
// Stall propagates stage by stage: a stage holds only while its successor is
// full and stalled, so bubbles collapse and in_stall rises only when all stages are full.
module radial_vignette_darkener_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_en,
  input  logic                        cfg_index,
  input  logic [rvd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rvd_pkg::COORD_W-1:0] pixel_x,
  input  logic [rvd_pkg::COORD_W-1:0] pixel_y,
  input  logic [rvd_pkg::CHAN_W-1:0]  red_in,
  input  logic [rvd_pkg::CHAN_W-1:0]  green_in,
  input  logic [rvd_pkg::CHAN_W-1:0]  blue_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rvd_pkg::CHAN_W-1:0]  red_out,
  output logic [rvd_pkg::CHAN_W-1:0]  green_out,
  output logic [rvd_pkg::CHAN_W-1:0]  blue_out
);
  import rvd_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic       front_ready;
  pix_t       pix_in;
  logic       cv [0:DIV_STEPS];
  cell_data_t cd [0:DIV_STEPS];
  logic       cr [0:DIV_STEPS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pix_in.red   = red_in;
  assign pix_in.green = green_in;
  assign pix_in.blue  = blue_in;
  assign in_stall     = !front_ready;

  rvd_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .in_valid    (in_valid),
    .up_ready    (front_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pix_in      (pix_in),
    .out_valid   (cv[0]),
    .out_data    (cd[0]),
    .down_ready  (cr[0])
  );

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    rvd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_data   (cd[k]),
      .up_ready  (cr[k]),
      .out_valid (cv[k+1]),
      .out_data  (cd[k+1]),
      .down_ready(cr[k+1])
    );
  end

  rvd_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cv[DIV_STEPS]),
    .in_data  (cd[DIV_STEPS]),
    .up_ready (cr[DIV_STEPS]),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red_out  (red_out),
    .green_out(green_out),
    .blue_out (blue_out)
  );

endmodule
